// ===== rtl/max_priority_queue_core_assert.svh =====
// Assertion macros for the max priority queue core.
`ifndef MAX_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define MPQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("max_priority_queue_core: assertion failed");
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("max_priority_queue_core: assertion failed");
`else
`define MPQ_ASSERT(lbl, clk, rst_n, prop)
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/mpq_pkg.sv =====
// Shared types, codes and helpers of the max priority queue core.
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned TagW         = 16;
  localparam int unsigned CountW       = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
  } entry_t;

  // Signed key compare a < b.
  function automatic logic key_less(logic signed [KeyW-1:0] a,
                                    logic signed [KeyW-1:0] b);
    return a < b;
  endfunction

endpackage

// ===== rtl/max_priority_queue_core.sv =====
// Top level of the max priority queue core: sequencer, compare unit and entry memory.
//
// Usage: present opcode_i, key_value_i and tag_value_i with start_i; the beat is
// taken at a rising edge where start_i is high and busy_o is low. opcode_i low
// inserts (key, tag); high pops the largest-key entry. Entries live in a sorted
// memory of DEPTH words; a single compare unit moves them one at a time.
// Every operation yields one result beat: done_o is high for exactly one cycle
// with out_key_o, out_tag_o, status_o and entry_count_o valid. The receiver
// cannot stall; the result is shown once and must be taken then.
// Insert into an empty queue, a rejected insert and a pop from an empty queue go
// straight to the finish state; an insert walks from the tail until it finds its
// slot, and a pop shifts the whole list down; each entry is read in the read state,
// then compared and written in the compare state. busy_o stays high until the
// result beat is shown; a new start may be taken in that same cycle.
// Reset clears the entry count and the sequencer; memory contents need no clear.
`timescale 1ns / 1ps

`include "max_priority_queue_core_assert.svh"

module max_priority_queue_core #(
  parameter int unsigned DEPTH = mpq_pkg::DefaultDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic signed [mpq_pkg::KeyW-1:0]     key_value_i,
  input  logic [mpq_pkg::TagW-1:0]            tag_value_i,
  output logic                                done_o,
  output logic signed [mpq_pkg::KeyW-1:0]     out_key_o,
  output logic [mpq_pkg::TagW-1:0]            out_tag_o,
  output logic [1:0]                          status_o,
  output logic [mpq_pkg::CountW-1:0]          entry_count_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_WNEW = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e                         st_q, st_d;
  logic                           op_q, op_d;
  mpq_pkg::entry_t                new_q, new_d;
  mpq_pkg::entry_t                pop_q, pop_d;
  logic [1:0]                     status_q, status_d;
  logic [AddrW-1:0]               idx_q, idx_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           done_q, done_d;

  logic                           accept;
  logic                           full;
  logic [AddrW-1:0]               last_idx;
  logic                           we;
  logic [AddrW-1:0]               waddr;
  mpq_pkg::entry_t                wdata;
  mpq_pkg::entry_t                rdata;
  mpq_pkg::entry_t                in_entry;

  assign accept   = start_i && (st_q == ST_IDLE);
  assign full     = (cnt_q == CntW'(DEPTH));
  assign last_idx = AddrW'(cnt_q - 1'b1);
  assign in_entry = '{key: key_value_i, tag: tag_value_i};

  always_comb begin
    st_d     = st_q;
    op_d     = op_q;
    new_d    = new_q;
    pop_d    = pop_q;
    status_d = status_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = new_q;

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = opcode_i;
          new_d    = in_entry;
          pop_d    = '0;
          status_d = mpq_pkg::STAT_OK;
          if (opcode_i == mpq_pkg::OP_INSERT) begin
            if (full) begin
              status_d = mpq_pkg::STAT_FULL;
              st_d     = ST_FIN;
            end else if (cnt_q == '0) begin
              we    = 1'b1;
              waddr = '0;
              wdata = in_entry;
              st_d  = ST_FIN;
            end else begin
              // walk from the tail toward the head
              idx_d = last_idx;
              st_d  = ST_READ;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = mpq_pkg::STAT_EMPTY;
              st_d     = ST_FIN;
            end else begin
              idx_d = '0;
              st_d  = ST_READ;
            end
          end
        end
      end

      ST_READ: begin
        st_d = ST_CMP;
      end

      ST_CMP: begin
        if (op_q == mpq_pkg::OP_INSERT) begin
          if (idx_q != '0) begin
            if (!mpq_pkg::key_less(new_q.key, rdata.key)) begin
              // stored key <= new key: move it up one slot
              we    = 1'b1;
              waddr = AddrW'(idx_q + 1'b1);
              wdata = rdata;
              idx_d = AddrW'(idx_q - 1'b1);
              st_d  = ST_READ;
            end else begin
              we    = 1'b1;
              waddr = AddrW'(idx_q + 1'b1);
              wdata = new_q;
              st_d  = ST_FIN;
            end
          end else if (mpq_pkg::key_less(rdata.key, new_q.key)) begin
            // head is strictly smaller: displace it
            we    = 1'b1;
            waddr = AddrW'(1);
            wdata = rdata;
            st_d  = ST_WNEW;
          end else begin
            we    = 1'b1;
            waddr = AddrW'(1);
            wdata = new_q;
            st_d  = ST_FIN;
          end
        end else begin
          if (idx_q == '0) begin
            pop_d = rdata;
          end else begin
            we    = 1'b1;
            waddr = AddrW'(idx_q - 1'b1);
            wdata = rdata;
          end
          if (idx_q == last_idx) begin
            st_d = ST_FIN;
          end else begin
            idx_d = AddrW'(idx_q + 1'b1);
            st_d  = ST_READ;
          end
        end
      end

      ST_WNEW: begin
        we    = 1'b1;
        waddr = '0;
        wdata = new_q;
        st_d  = ST_FIN;
      end

      ST_FIN: begin
        if (status_q == mpq_pkg::STAT_OK) begin
          if (op_q == mpq_pkg::OP_INSERT) begin
            cnt_d = CntW'(cnt_q + 1'b1);
          end else begin
            cnt_d = CntW'(cnt_q - 1'b1);
          end
        end
        done_d = 1'b1;
        st_d   = ST_IDLE;
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      status_q <= mpq_pkg::STAT_OK;
      pop_q    <= '0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      status_q <= status_d;
      pop_q    <= pop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    new_q <= new_d;
    idx_q <= idx_d;
  end

  mpq_store #(
    .Depth (DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign busy_o        = (st_q != ST_IDLE);
  assign done_o        = done_q;
  assign out_key_o     = pop_q.key;
  assign out_tag_o     = pop_q.tag;
  assign status_o      = status_q;
  assign entry_count_o = mpq_pkg::CountW'(cnt_q);

  `MPQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(DEPTH))
  `MPQ_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q)
  `MPQ_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o)
  `MPQ_ASSERT(a_waddr_range, clk_i, rst_ni, we |-> (CntW'(waddr) <= cnt_q))
  `MPQ_ASSERT(a_done_after_fin, clk_i, rst_ni, done_q |-> $past(st_q == ST_FIN))

endmodule

// ===== rtl/mpq_store.sv =====
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module mpq_store #(
  parameter int unsigned Depth = mpq_pkg::DefaultDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  mpq_pkg::entry_t     wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output mpq_pkg::entry_t     rdata_o
);

  mpq_pkg::entry_t mem_q [Depth];
  mpq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
